[hdl/prefixed_base64_byte_decoder_macros.svh]
// Assertion macros used by the decoder's checker file.
`ifndef PREFIXED_BASE64_BYTE_DECODER_MACROS_SVH
`define PREFIXED_BASE64_BYTE_DECODER_MACROS_SVH

// Same-cycle implication, disabled while reset is high.
`define PB64_ASSERT_NOW(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("pb64 assertion failed");

// Next-cycle implication, disabled while reset is high.
`define PB64_ASSERT_NEXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("pb64 assertion failed");

`endif

[hdl/pb64_pkg.sv]
// Shared types, constants and the symbol map of the prefixed base64 decoder.
`default_nettype none
package pb64_pkg;

  localparam logic [7:0] CHAR_COLON = 8'h3A;
  localparam logic [6:0] NO_SYMBOL = 7'd64;
  localparam logic signed [4:0] BIT_COUNT_RESET = -5'sd8;
  localparam int QUEUE_DEPTH_DEFAULT = 4;

  // One queued result group: an optional held colon, then the final result.
  typedef struct packed {
    logic       colon_first;
    logic       has_byte;
    logic [7:0] data;
    logic       msg_end;
  } pb64_entry_t;

  typedef struct packed {
    logic        valid;
    pb64_entry_t entry;
  } pb64_push_t;

  // Map a character to its base64 value, or NO_SYMBOL.
  function automatic logic [6:0] symbol_value(input logic [7:0] c);
    logic [7:0] d;
    if (c >= 8'h41 && c <= 8'h5A) begin
      d = c - 8'h41;
    end else if (c >= 8'h61 && c <= 8'h7A) begin
      d = c - 8'h47;
    end else if (c >= 8'h30 && c <= 8'h39) begin
      d = c + 8'h04;
    end else if (c == 8'h2B) begin
      d = 8'd62;
    end else if (c == 8'h2F) begin
      d = 8'd63;
    end else begin
      d = {1'b0, NO_SYMBOL};
    end
    return d[6:0];
  endfunction

endpackage
`default_nettype wire

[hdl/pb64_front.sv]
// Front end: accepts characters, tracks prefix and decode state, emits result groups.
`default_nettype none
module pb64_front
  import pb64_pkg::*;
(
  input  wire logic       clk,
  input  wire logic       rst,
  input  wire logic       s_tvalid,
  output logic            s_tready,
  input  wire logic [7:0] s_tdata,   // [7:0] in_char
  input  wire logic       s_tlast,
  input  wire logic       q_full,
  output pb64_push_t      push
);

  localparam logic [2:0] MODE_START  = 3'd0;
  localparam logic [2:0] MODE_COLON  = 3'd1;
  localparam logic [2:0] MODE_PASS   = 3'd2;
  localparam logic [2:0] MODE_DECODE = 3'd3;
  localparam logic [2:0] MODE_HALTED = 3'd4;

  logic [2:0]        mode, mode_next;
  logic [11:0]       acc, acc_next;
  logic signed [4:0] cnt, cnt_next;
  logic              accept;
  logic              emit;
  pb64_entry_t       entry;
  logic [6:0]        sym;
  logic [11:0]       acc_shift;
  logic signed [4:0] cnt_add;
  logic [11:0]       shifted;

  assign s_tready = !q_full;
  assign accept   = s_tvalid && s_tready;

  // Shift in one symbol and locate the next byte
  assign sym       = symbol_value(s_tdata);
  assign acc_shift = {acc[5:0], sym[5:0]};
  assign cnt_add   = cnt + 5'sd6;
  assign shifted   = acc_shift >> cnt_add[2:0];

  // Classify the character against the current mode
  always_comb begin
    mode_next = mode;
    acc_next  = acc;
    cnt_next  = cnt;
    emit      = 1'b0;
    entry     = '0;
    unique case (mode)
      MODE_START: begin
        if (s_tdata == CHAR_COLON && !s_tlast) begin
          mode_next = MODE_COLON;
        end else begin
          emit           = 1'b1;
          entry.has_byte = 1'b1;
          entry.data     = s_tdata;
          entry.msg_end  = s_tlast;
          mode_next      = MODE_PASS;
        end
      end
      MODE_COLON: begin
        if (s_tdata == CHAR_COLON) begin
          mode_next = MODE_DECODE;
          if (s_tlast) begin
            emit          = 1'b1;
            entry.msg_end = 1'b1;
          end
        end else begin
          emit              = 1'b1;
          entry.colon_first = 1'b1;
          entry.has_byte    = 1'b1;
          entry.data        = s_tdata;
          entry.msg_end     = s_tlast;
          mode_next         = MODE_PASS;
        end
      end
      MODE_PASS: begin
        emit           = 1'b1;
        entry.has_byte = 1'b1;
        entry.data     = s_tdata;
        entry.msg_end  = s_tlast;
      end
      MODE_DECODE: begin
        if (sym[6]) begin
          mode_next = MODE_HALTED;
          if (s_tlast) begin
            emit          = 1'b1;
            entry.msg_end = 1'b1;
          end
        end else begin
          acc_next = acc_shift;
          cnt_next = cnt_add;
          if (!cnt_add[4]) begin
            cnt_next       = cnt_add - 5'sd8;
            emit           = 1'b1;
            entry.has_byte = 1'b1;
            entry.data     = shifted[7:0];
            entry.msg_end  = s_tlast;
          end else if (s_tlast) begin
            emit          = 1'b1;
            entry.msg_end = 1'b1;
          end
        end
      end
      default: begin
        mode_next = MODE_HALTED;
        if (s_tlast) begin
          emit          = 1'b1;
          entry.msg_end = 1'b1;
        end
      end
    endcase
    // Return to the start of a message after its last character
    if (s_tlast) begin
      mode_next = MODE_START;
      acc_next  = '0;
      cnt_next  = BIT_COUNT_RESET;
    end
  end

  assign push = '{valid: accept && emit, entry: entry};

  // Advance state on each accepted character
  always_ff @(posedge clk) begin
    if (rst) begin
      mode <= MODE_START;
      acc  <= '0;
      cnt  <= BIT_COUNT_RESET;
    end else if (accept) begin
      mode <= mode_next;
      acc  <= acc_next;
      cnt  <= cnt_next;
    end
  end

endmodule
`default_nettype wire

[hdl/pb64_queue.sv]
// Small FIFO of result groups between the front and back ends.
`default_nettype none
module pb64_queue
  import pb64_pkg::*;
#(
  parameter int DEPTH = QUEUE_DEPTH_DEFAULT
) (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire pb64_push_t  push,
  input  wire logic        pop,
  output pb64_entry_t      head,
  output logic             full,
  output logic             empty
);

  localparam int PtrW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CntW = $clog2(DEPTH + 1);
  localparam logic [PtrW-1:0] PtrLast = PtrW'(DEPTH - 1);
  localparam logic [CntW-1:0] CntFull = CntW'(DEPTH);

  pb64_entry_t     mem [DEPTH];
  logic [PtrW-1:0] wr_ptr, rd_ptr;
  logic [CntW-1:0] count;
  logic            do_push, do_pop;

  assign full    = (count == CntFull);
  assign empty   = (count == '0);
  assign do_push = push.valid && !full;
  assign do_pop  = pop && !empty;
  assign head    = mem[rd_ptr];

  // Store pushed groups
  always_ff @(posedge clk) begin
    if (do_push) begin
      mem[wr_ptr] <= push.entry;
    end
  end

  // Advance pointers and occupancy
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= (wr_ptr == PtrLast) ? '0 : wr_ptr + 1'b1;
      end
      if (do_pop) begin
        rd_ptr <= (rd_ptr == PtrLast) ? '0 : rd_ptr + 1'b1;
      end
      if (do_push && !do_pop) begin
        count <= count + 1'b1;
      end else if (do_pop && !do_push) begin
        count <= count - 1'b1;
      end
    end
  end

endmodule
`default_nettype wire

[hdl/pb64_back.sv]
// Back end: unpacks queued groups into single results on the output register.
`default_nettype none
module pb64_back
  import pb64_pkg::*;
(
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire pb64_entry_t head,
  input  wire logic        q_empty,
  output logic             q_pop,
  output logic             m_tvalid,
  input  wire logic        m_tready,
  output logic [15:0]      m_tdata,   // [7:0] out_byte, [8] run_last, [15:9] zero
  output logic             m_tlast,
  output logic             m_tuser    // [0] has_byte
);

  logic       out_free;
  logic       load;
  logic       colon_now;
  logic       phase;
  logic [7:0] out_data;
  logic       out_run_last;

  assign out_free  = !m_tvalid || m_tready;
  assign load      = out_free && !q_empty;
  assign colon_now = head.colon_first && !phase;
  assign q_pop     = load && !colon_now;

  assign m_tdata = {7'b0, out_run_last, out_data};

  // Hold or refill the output register
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
      phase    <= 1'b0;
    end else begin
      if (out_free) begin
        m_tvalid <= !q_empty;
      end
      if (load) begin
        phase <= colon_now;
      end
    end
  end

  // Drive the held colon first, then the group's own result
  always_ff @(posedge clk) begin
    if (load) begin
      if (colon_now) begin
        out_data     <= CHAR_COLON;
        m_tuser      <= 1'b1;
        out_run_last <= 1'b0;
        m_tlast      <= 1'b0;
      end else begin
        out_data     <= head.has_byte ? head.data : 8'h00;
        m_tuser      <= head.has_byte;
        out_run_last <= 1'b1;
        m_tlast      <= head.msg_end;
      end
    end
  end

endmodule
`default_nettype wire

[hdl/prefixed_base64_byte_decoder.sv]
// Top level of the prefixed base64 byte decoder.
// Takes one character per cycle on the slave stream (tlast marks the last
// character of a message) and gives results on the master stream. A message
// that starts with "::" is base64-decoded after the prefix, anything else
// passes through byte for byte. The front end accepts a character every
// cycle while its group queue has room; the back end puts out one result per
// cycle unless the output stalls, so a character that releases a held colon
// along with itself gives two results, any other at most one. A result is
// registered in the queue and then the output register. Every message ends
// with a tlast result, byte or not (tuser says whether tdata carries one).
`default_nettype none
module prefixed_base64_byte_decoder
  import pb64_pkg::*;
#(
  parameter int QUEUE_DEPTH = QUEUE_DEPTH_DEFAULT
) (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        s_tvalid,
  output logic             s_tready,
  input  wire logic [7:0]  s_tdata,   // [7:0] in_char
  input  wire logic        s_tlast,
  output logic             m_tvalid,
  input  wire logic        m_tready,
  output logic [15:0]      m_tdata,   // [7:0] out_byte, [8] run_last, [15:9] zero
  output logic             m_tlast,
  output logic             m_tuser    // [0] has_byte
);

  pb64_push_t  push;
  pb64_entry_t head;
  logic        q_full, q_empty, q_pop;

  pb64_front u_front (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tlast  (s_tlast),
    .q_full   (q_full),
    .push     (push)
  );

  pb64_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk   (clk),
    .rst   (rst),
    .push  (push),
    .pop   (q_pop),
    .head  (head),
    .full  (q_full),
    .empty (q_empty)
  );

  pb64_back u_back (
    .clk      (clk),
    .rst      (rst),
    .head     (head),
    .q_empty  (q_empty),
    .q_pop    (q_pop),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tlast  (m_tlast),
    .m_tuser  (m_tuser)
  );

endmodule
`default_nettype wire

[hdl/pb64_checker.sv]
// Port-level checks of the decoder's output stream, bound to the top level.
`default_nettype none
`include "prefixed_base64_byte_decoder_macros.svh"
module pb64_checker
  import pb64_pkg::*;
(
  input wire logic        clk,
  input wire logic        rst,
  input wire logic        m_tvalid,
  input wire logic        m_tready,
  input wire logic [15:0] m_tdata,
  input wire logic        m_tlast,
  input wire logic        m_tuser
);

  logic [17:0] out_word;
  logic [7:0]  out_byte;
  logic        run_last;

  // Split the output transfer into its fields
  assign out_word = {m_tuser, m_tlast, m_tdata};
  assign out_byte = m_tdata[7:0];
  assign run_last = m_tdata[8];

  // A stalled result holds
  `PB64_ASSERT_NEXT(a_hold, clk, rst, m_tvalid && !m_tready, m_tvalid && $stable(out_word))

  // Only a released colon can come before another result of the same character
  `PB64_ASSERT_NOW(a_lead_colon, clk, rst, m_tvalid && !run_last, m_tuser && out_byte == CHAR_COLON && !m_tlast)

  // A byte-less result only ever closes a message, with a zero byte
  `PB64_ASSERT_NOW(a_empty_end, clk, rst, m_tvalid && !m_tuser, m_tlast && run_last && out_byte == 8'h00)

  // Padding bits stay clear
  `PB64_ASSERT_NOW(a_pad_zero, clk, rst, m_tvalid, m_tdata[15:9] == 7'd0)

endmodule

bind prefixed_base64_byte_decoder pb64_checker u_pb64_checker (.*);
`default_nettype wire

[tb/sv/tb_prefixed_base64_byte_decoder.sv]
// Self-checking testbench for the prefixed base64 byte decoder stream block.
`timescale 1ns / 1ps
module tb_prefixed_base64_byte_decoder;
  import pb64_pkg::*;

  localparam int CYCLE_LIMIT = 200000;
  localparam int DRAIN_CYCLES = 8;
  localparam int IDLE_PERCENT = 28;
  localparam string B64_ALPHABET =
    "ABCDEFGHIJKLMNOPQRSTUVWXYZabcdefghijklmnopqrstuvwxyz0123456789+/";
  localparam logic [7:0] CHAR_PAD = 8'h3D;

  // Decoder modes of the prediction
  typedef enum logic [2:0] {
    MODE_START,
    MODE_COLON,
    MODE_PASS,
    MODE_DECODE,
    MODE_HALTED
  } decode_mode_e;

  // One output transfer as predicted
  typedef struct packed {
    logic       has_byte;
    logic [7:0] data;
    logic       run_last;
    logic       msg_end;
  } out_item_t;

  logic        clk;
  logic        rst;
  logic        s_tvalid;
  logic        s_tready;
  logic [7:0]  s_tdata;
  logic        s_tlast;
  logic        m_tvalid;
  logic        m_tready = 1'b0;
  logic [15:0] m_tdata;
  logic        m_tlast;
  logic        m_tuser;

  // Prediction state
  decode_mode_e mode_q;
  logic [11:0]  sextet_acc;
  int           pending_bits;
  out_item_t    predicted_q[$];

  int          error_count = 0;
  int          chars_sent;
  int          cycle_count = 0;
  logic        steady;
  logic [7:0]  msg_buf [0:19];
  int          msg_len;

  prefixed_base64_byte_decoder u_top (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tlast  (s_tlast),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tlast  (m_tlast),
    .m_tuser  (m_tuser)
  );

  // Free-running clock, 8 ns period
  always begin
    clk = 1'b0;
    #4;
    clk = 1'b1;
    #4;
  end

  // Stall the output side at random unless in a steady stretch
  always @(negedge clk) begin
    m_tready <= steady ? 1'b1 : ($urandom_range(99) >= IDLE_PERCENT);
  end

  // Abort a hung run
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("%0t: timeout after %0d cycles", $time, cycle_count);
      $display("tb_prefixed_base64_byte_decoder NOT OK");
      $finish;
    end
  end

  // Map a character to its 6-bit value; bit 6 flags a non-symbol
  function automatic logic [6:0] sextet_of(input logic [7:0] c);
    if (c >= "A" && c <= "Z") return {1'b0, 6'(c - 8'd65)};
    if (c >= "a" && c <= "z") return {1'b0, 6'(c - 8'd71)};
    if (c >= "0" && c <= "9") return {1'b0, 6'(c + 8'd4)};
    if (c == "+") return 7'd62;
    if (c == "/") return 7'd63;
    return 7'h40;
  endfunction

  function automatic void push_result(input logic has, input logic [7:0] b,
                                      input logic rl, input logic me);
    out_item_t it;
    it.has_byte = has;
    it.data     = has ? b : 8'h00;
    it.run_last = rl;
    it.msg_end  = me;
    predicted_q.insert(predicted_q.size(), it);
  endfunction

  // Advance the prediction by one accepted character
  function automatic void decode_char(input logic [7:0] c, input logic last);
    logic [6:0]  sx;
    logic [11:0] shifted;
    case (mode_q)
      MODE_START: begin
        if (c == CHAR_COLON && !last) begin
          mode_q = MODE_COLON;
        end else begin
          push_result(1'b1, c, 1'b1, last);
          mode_q = MODE_PASS;
        end
      end
      MODE_COLON: begin
        if (c == CHAR_COLON) begin
          mode_q = MODE_DECODE;
          if (last) push_result(1'b0, 8'h00, 1'b1, 1'b1);
        end else begin
          // release the held colon ahead of this character
          push_result(1'b1, CHAR_COLON, 1'b0, 1'b0);
          push_result(1'b1, c, 1'b1, last);
          mode_q = MODE_PASS;
        end
      end
      MODE_PASS: begin
        push_result(1'b1, c, 1'b1, last);
      end
      MODE_DECODE: begin
        sx = sextet_of(c);
        if (sx[6]) begin
          mode_q = MODE_HALTED;
          if (last) push_result(1'b0, 8'h00, 1'b1, 1'b1);
        end else begin
          sextet_acc = {sextet_acc[5:0], sx[5:0]};
          pending_bits += 6;
          if (pending_bits >= 0) begin
            shifted = sextet_acc >> pending_bits;
            pending_bits -= 8;
            push_result(1'b1, shifted[7:0], 1'b1, last);
          end else if (last) begin
            push_result(1'b0, 8'h00, 1'b1, 1'b1);
          end
        end
      end
      default: begin
        mode_q = MODE_HALTED;
        if (last) push_result(1'b0, 8'h00, 1'b1, 1'b1);
      end
    endcase
    // a message end returns everything to its start state
    if (last) begin
      mode_q       = MODE_START;
      sextet_acc   = '0;
      pending_bits = -8;
    end
  endfunction

  // Compare each output transfer with the oldest prediction
  always @(posedge clk) begin
    out_item_t want;
    if (!rst && m_tvalid && m_tready) begin
      if (predicted_q.size() == 0) begin
        $display("%0t: unexpected output: expected none, got has=%0b data=%h rl=%0b end=%0b",
                 $time, m_tuser, m_tdata[7:0], m_tdata[8], m_tlast);
        error_count++;
      end else begin
        want = predicted_q.pop_front();
        if (m_tuser !== want.has_byte) begin
          $display("%0t: has_byte mismatch: expected %0b, got %0b",
                   $time, want.has_byte, m_tuser);
          error_count++;
        end
        if (m_tdata[7:0] !== want.data) begin
          $display("%0t: out_byte mismatch: expected %h, got %h",
                   $time, want.data, m_tdata[7:0]);
          error_count++;
        end
        if (m_tdata[8] !== want.run_last) begin
          $display("%0t: run_last mismatch: expected %0b, got %0b",
                   $time, want.run_last, m_tdata[8]);
          error_count++;
        end
        if (m_tlast !== want.msg_end) begin
          $display("%0t: message_end mismatch: expected %0b, got %0b",
                   $time, want.msg_end, m_tlast);
          error_count++;
        end
      end
    end
  end

  // Send one character; called and returning at a falling edge
  task automatic send_char(input logic [7:0] c, input logic last);
    while (!steady && $urandom_range(99) < IDLE_PERCENT) begin
      s_tvalid = 1'b0;
      @(negedge clk);
    end
    s_tdata  = c;
    s_tlast  = last;
    s_tvalid = 1'b1;
    do @(posedge clk); while (!s_tready);
    decode_char(c, last);
    chars_sent++;
    @(negedge clk);
  endtask

  // Send msg_buf[0 .. msg_len-1] as one message
  task automatic send_buffer();
    for (int i = 0; i < msg_len; i++) begin
      send_char(msg_buf[i], i == msg_len - 1);
    end
  endtask

  task automatic send_text(input string txt);
    for (int i = 0; i < txt.len(); i++) begin
      send_char(txt[i], i == txt.len() - 1);
    end
  endtask

  // Build one random message of a random shape into msg_buf
  task automatic build_random_message();
    int kind;
    int n;
    kind = $urandom_range(99);
    if (kind < 55) begin
      // prefixed base64, mostly clean, sometimes broken or padded
      msg_buf[0] = CHAR_COLON;
      msg_buf[1] = CHAR_COLON;
      n = $urandom_range(12);
      for (int i = 0; i < n; i++) begin
        msg_buf[2 + i] = B64_ALPHABET[$urandom_range(63)];
      end
      msg_len = 2 + n;
      if (n > 0 && $urandom_range(99) < 15) begin
        msg_buf[2 + $urandom_range(n - 1)] = 8'($urandom_range(255));
      end
      if ($urandom_range(99) < 15) begin
        msg_buf[msg_len] = CHAR_PAD;
        msg_len++;
        if ($urandom_range(1)) begin
          msg_buf[msg_len] = 8'($urandom_range(255));
          msg_len++;
        end
      end
    end else if (kind < 75) begin
      // plain pass-through of arbitrary bytes
      msg_len = $urandom_range(1, 8);
      for (int i = 0; i < msg_len; i++) begin
        msg_buf[i] = 8'($urandom_range(255));
      end
    end else if (kind < 90) begin
      // a colon, then up to four random followers, some of them colons
      msg_buf[0] = CHAR_COLON;
      msg_len = $urandom_range(1, 5);
      for (int i = 1; i < msg_len; i++) begin
        msg_buf[i] = ($urandom_range(3) == 0) ? CHAR_COLON : 8'($urandom_range(255));
      end
    end else begin
      // noise made of colons and symbol characters
      msg_len = $urandom_range(1, 6);
      for (int i = 0; i < msg_len; i++) begin
        msg_buf[i] = $urandom_range(1) ? CHAR_COLON : B64_ALPHABET[$urandom_range(63)];
      end
    end
  endtask

  task automatic run_random_messages(input int n_chars);
    int target;
    target = chars_sent + n_chars;
    while (chars_sent < target) begin
      build_random_message();
      send_buffer();
    end
  endtask

  // Extremes and every corner of the prefix and decode logic
  task automatic test_directed_cases();
    send_text(":");          // lone colon
    send_text(":b");         // colon then other
    send_text("::");         // prefix only
    send_text("::TWFu");     // three full bytes, last one ends the message
    send_text("::QQ==");     // two symbols give one byte, padding halts
    send_char(8'h00, 1'b1);
    send_char(8'hFF, 1'b1);
    send_text("a::");        // colons later in a message pass through
    send_text("::+/90za");   // plus, slash, digit and lower-case symbols
  endtask

  // Both sides always ready
  task automatic test_back_to_back();
    steady = 1'b1;
    run_random_messages(150);
    steady = 1'b0;
  endtask

  task automatic test_random_traffic();
    run_random_messages(260);
  endtask

  initial begin
    rst          = 1'b1;
    s_tvalid     = 1'b0;
    s_tdata      = 8'h00;
    s_tlast      = 1'b0;
    steady       = 1'b0;
    chars_sent   = 0;
    mode_q       = MODE_START;
    sextet_acc   = '0;
    pending_bits = -8;
    repeat (8) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    test_directed_cases();
    test_random_traffic();
    test_back_to_back();
    test_random_traffic();
    s_tvalid = 1'b0;

    // drain outstanding results, then allow the pipeline to settle
    while (predicted_q.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    if (error_count == 0) begin
      $display("tb_prefixed_base64_byte_decoder OK");
    end else begin
      $display("tb_prefixed_base64_byte_decoder NOT OK");
    end
    $finish;
  end

endmodule
